FILE: rtl/scmva_pkg.sv
// Shared types and codes for the sparse column matvec accumulate block.
package scmva_pkg;

	// Operation codes carried by an input item
	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_LOAD  = 2'd1,
		OP_ACC   = 2'd2,
		OP_READ  = 2'd3
	} opcode_t;

	// Controller states, one-hot
	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_RD    = 8'b0000_0010,
		ST_MUL   = 8'b0000_0100,
		ST_MNORM = 8'b0000_1000,
		ST_MPACK = 8'b0001_0000,
		ST_ADD   = 8'b0010_0000,
		ST_ANORM = 8'b0100_0000,
		ST_APACK = 8'b1000_0000
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic wr_entry;   // write data_value into the addressed entry
		logic ld_col;     // latch the column vector element
		logic rd_entry;   // start an entry read
		logic acc_start;  // start an accumulate: read entry, latch matrix value
		logic out_load;   // move read data into the output register
		logic mul;        // multiply matrix value by column element
		logic norm;       // one normalize step
		logic mpack;      // round and pack the product
		logic add;        // align and add entry and product
		logic apack;      // round, pack and write back the sum
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic in_range;   // row_index addresses a stored entry
		logic norm_done;  // mantissa is normalized or zero
	} status_t;

	localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
	localparam logic [30:0] INF_MAG   = 31'h7F80_0000;

endpackage

FILE: rtl/sparse_column_matvec_accumulate.sv
// Top level: sparse column matvec scatter-accumulate engine.
//
//  channel | valid     | stall      | payload
//  --------+-----------+------------+-----------------------------------
//  input   | in_valid  | in_stall   | operation, row_index, data_value
//  output  | out_valid | out_stall  | read_value
//
// Write and load-column items complete when taken. A read passes the RAM
// read register, moves to the output register once that is free and waits
// there; the next item is taken meanwhile. Accumulates share one normalizer
// and step through multiply, normalize, pack, add, normalize and write-back;
// each normalize step shifts 8 or 1 bit, up to 12 for product and 6 for sum.
// Reset clears the column element to +0.0; the entry store is not cleared.
// in_stall is high while a read or accumulate is in progress.
module sparse_column_matvec_accumulate
	import scmva_pkg::*;
#(
	parameter int ROW_COUNT = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [9:0]  row_index,
	input  logic [31:0] data_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] read_value
);

	cmd_t    cmd;
	status_t status;

	scmva_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (opcode_t'(operation)),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	scmva_dp #(.ROW_COUNT(ROW_COUNT)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.row_index  (row_index),
		.data_value (data_value),
		.cmd        (cmd),
		.status     (status),
		.read_value (read_value)
	);

endmodule

FILE: rtl/scmva_ram.sv
// Generic simple dual-port RAM with registered read.
module scmva_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic                             re,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/scmva_ctrl.sv
// Controller state machine: input/output handshakes and operation sequencing.
module scmva_ctrl
	import scmva_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  opcode_t op,
	output logic    out_valid,
	input  logic    out_stall,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   accept;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// Command decode
	always_comb begin
		cmd           = '0;
		cmd.wr_entry  = accept && (op == OP_WRITE) && status.in_range;
		cmd.ld_col    = accept && (op == OP_LOAD);
		cmd.rd_entry  = accept && (op == OP_READ);
		cmd.acc_start = accept && (op == OP_ACC) && status.in_range;
		cmd.out_load  = (state_q == ST_RD) && (!out_valid_q || !out_stall);
		cmd.mul       = (state_q == ST_MUL);
		cmd.norm      = ((state_q == ST_MNORM) || (state_q == ST_ANORM)) && !status.norm_done;
		cmd.mpack     = (state_q == ST_MPACK);
		cmd.add       = (state_q == ST_ADD);
		cmd.apack     = (state_q == ST_APACK);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.rd_entry) state_d = ST_RD;
				else if (cmd.acc_start) state_d = ST_MUL;
			end
			ST_RD: begin
				if (cmd.out_load) state_d = ST_IDLE;
			end
			ST_MUL:   state_d = ST_MNORM;
			ST_MNORM: begin
				if (status.norm_done) state_d = ST_MPACK;
			end
			ST_MPACK: state_d = ST_ADD;
			ST_ADD:   state_d = ST_ANORM;
			ST_ANORM: begin
				if (status.norm_done) state_d = ST_APACK;
			end
			ST_APACK: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

endmodule

FILE: rtl/scmva_dp.sv
// Datapath: entry store, binary32 multiply and add with shared normalizer.
module scmva_dp
	import scmva_pkg::*;
#(
	parameter int ROW_COUNT = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [9:0]  row_index,
	input  logic [31:0] data_value,
	input  cmd_t        cmd,
	output status_t     status,
	output logic [31:0] read_value
);

	localparam int AW = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;

	logic [AW-1:0]      addr_in, row_q, waddr;
	logic [31:0]        col_q, mval_q, acc_q, prod_q, out_q, spec_bits_q;
	logic [31:0]        rdata, wdata;
	logic               rd_range_q, spec_q, ns_q, in_range;
	logic [47:0]        nm_q;
	logic signed [11:0] ne_q;

	assign addr_in    = AW'(row_index);
	assign in_range   = ({22'd0, row_index} < 32'(ROW_COUNT));
	assign read_value = out_q;

	// Round to nearest even and pack; value is m * 2^(e - 174), m has msb at 47
	function automatic logic [31:0] round_pack(input logic s, input logic signed [11:0] e,
		input logic [47:0] m);
		logic [11:0] sh;
		logic [47:0] sr;
		logic        lost, g, st, rnd;
		logic [23:0] mant;
		logic [24:0] sum;
		logic [11:0] base;
		logic [35:0] mag;
		begin
			sh   = 12'd0;
			lost = 1'b0;
			sr   = m;
			if (e < 12'sd1) begin
				sh = 12'(12'sd1 - e);
				if (sh >= 12'd48) begin
					sr   = '0;
					lost = |m;
				end else begin
					sr   = m >> sh[5:0];
					lost = |(m & ((48'd1 << sh[5:0]) - 48'd1));
				end
			end
			mant = sr[47:24];
			g    = sr[23];
			st   = (|sr[22:0]) | lost;
			rnd  = g & (st | mant[0]);
			sum  = {1'b0, mant} + {24'd0, rnd};
			base = (e >= 12'sd1) ? 12'(e - 12'sd1) : 12'd0;
			mag  = {1'b0, base, 23'd0} + {11'd0, sum};
			if (m == '0) round_pack = {s, 31'd0};
			else if (mag >= {5'd0, INF_MAG}) round_pack = {s, INF_MAG};
			else round_pack = {s, mag[30:0]};
		end
	endfunction

	// Entry store
	assign waddr = cmd.apack ? row_q : addr_in;
	assign wdata = cmd.apack ? ((spec_q ? spec_bits_q : round_pack(ns_q, ne_q, nm_q)))
		: data_value;

	scmva_ram #(.WIDTH(32), .DEPTH(ROW_COUNT)) u_ram (
		.clk   (clk),
		.we    (cmd.wr_entry || cmd.apack),
		.waddr (waddr),
		.wdata ((cmd.apack && (wdata[30:23] == 8'hFF) && (wdata[22:0] != '0))
			? CANON_NAN : wdata),
		.re    (cmd.rd_entry || cmd.acc_start),
		.raddr (addr_in),
		.rdata (rdata)
	);

	// Normalize status
	assign status.in_range  = in_range;
	assign status.norm_done = nm_q[47] || (nm_q == '0);

	// Multiply operands
	logic [7:0]  ma_e, mb_e;
	logic [23:0] ma_m, mb_m;
	logic        ma_nan, mb_nan, ma_inf, mb_inf, ma_zero, mb_zero, m_sign;
	assign ma_e    = (mval_q[30:23] == 8'd0) ? 8'd1 : mval_q[30:23];
	assign mb_e    = (col_q[30:23] == 8'd0) ? 8'd1 : col_q[30:23];
	assign ma_m    = {mval_q[30:23] != 8'd0, mval_q[22:0]};
	assign mb_m    = {col_q[30:23] != 8'd0, col_q[22:0]};
	assign ma_nan  = (mval_q[30:23] == 8'hFF) && (mval_q[22:0] != '0);
	assign mb_nan  = (col_q[30:23] == 8'hFF) && (col_q[22:0] != '0);
	assign ma_inf  = (mval_q[30:0] == INF_MAG);
	assign mb_inf  = (col_q[30:0] == INF_MAG);
	assign ma_zero = (mval_q[30:0] == '0);
	assign mb_zero = (col_q[30:0] == '0);
	assign m_sign  = mval_q[31] ^ col_q[31];

	// Add operands: entry and rounded product
	logic        a_big, sa, sb, s_big;
	logic [7:0]  ea, eb, e_big, e_small, d;
	logic [23:0] ma, mb;
	logic [26:0] x_small, y_big, x_sh;
	logic [27:0] add_sum;
	logic        a_nan, b_nan, a_inf, b_inf;
	assign sa      = acc_q[31];
	assign sb      = prod_q[31];
	assign ea      = (acc_q[30:23] == 8'd0) ? 8'd1 : acc_q[30:23];
	assign eb      = (prod_q[30:23] == 8'd0) ? 8'd1 : prod_q[30:23];
	assign ma      = {acc_q[30:23] != 8'd0, acc_q[22:0]};
	assign mb      = {prod_q[30:23] != 8'd0, prod_q[22:0]};
	assign a_big   = (acc_q[30:0] >= prod_q[30:0]);
	assign s_big   = a_big ? sa : sb;
	assign e_big   = a_big ? ea : eb;
	assign e_small = a_big ? eb : ea;
	assign y_big   = {(a_big ? ma : mb), 3'b000};
	assign x_small = {(a_big ? mb : ma), 3'b000};
	assign d       = e_big - e_small;
	assign a_nan   = (acc_q[30:23] == 8'hFF) && (acc_q[22:0] != '0);
	assign b_nan   = (prod_q[30:23] == 8'hFF) && (prod_q[22:0] != '0);
	assign a_inf   = (acc_q[30:0] == INF_MAG);
	assign b_inf   = (prod_q[30:0] == INF_MAG);

	// Alignment shift with sticky
	always_comb begin
		if (d >= 8'd27) begin
			x_sh = {26'd0, |x_small};
		end else begin
			x_sh = (x_small >> d[4:0])
				| {26'd0, |(x_small & ((27'd1 << d[4:0]) - 27'd1))};
		end
		add_sum = (sa ^ sb) ? ({1'b0, y_big} - {1'b0, x_sh})
			: ({1'b0, y_big} + {1'b0, x_sh});
	end

	// Registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (cmd.ld_col) begin
			col_q <= data_value;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_entry) rd_range_q <= in_range;
		if (cmd.out_load) out_q <= rd_range_q ? rdata : 32'd0;
		if (cmd.acc_start) begin
			mval_q <= data_value;
			row_q  <= addr_in;
		end
		if (cmd.mul) begin
			acc_q  <= rdata;
			nm_q   <= ma_m * mb_m;
			ne_q   <= 12'(signed'({4'd0, ma_e}) + signed'({4'd0, mb_e}) - 12'sd126);
			ns_q   <= m_sign;
			spec_q <= ma_nan || mb_nan || ma_inf || mb_inf;
			if (ma_nan || mb_nan || (ma_inf && mb_zero) || (mb_inf && ma_zero)) begin
				spec_bits_q <= CANON_NAN;
			end else begin
				spec_bits_q <= {m_sign, INF_MAG};
			end
		end
		if (cmd.norm) begin
			if (nm_q[47:40] == 8'd0) begin
				nm_q <= {nm_q[39:0], 8'd0};
				ne_q <= ne_q - 12'sd8;
			end else begin
				nm_q <= {nm_q[46:0], 1'b0};
				ne_q <= ne_q - 12'sd1;
			end
		end
		if (cmd.mpack) begin
			prod_q <= spec_q ? spec_bits_q : round_pack(ns_q, ne_q, nm_q);
		end
		if (cmd.add) begin
			nm_q   <= {add_sum, 20'd0};
			ne_q   <= 12'(signed'({4'd0, e_big}) + 12'sd1);
			ns_q   <= (add_sum == '0) ? (sa & sb) : s_big;
			spec_q <= a_nan || b_nan || a_inf || b_inf;
			if (a_nan || b_nan || (a_inf && b_inf && (sa != sb))) begin
				spec_bits_q <= CANON_NAN;
			end else begin
				spec_bits_q <= a_inf ? acc_q : prod_q;
			end
		end
	end

endmodule

FILE: tb/sv/sparse_column_matvec_accumulate_tb.sv
// Testbench for the sparse column matvec accumulate block: directed table plus random column loops.
module sparse_column_matvec_accumulate_tb;
	import scmva_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ENTRIES      = 1024;
	localparam int RANDOM_ITEMS = 850;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int DIRECTED_N   = 25;
	localparam int LONG_HOLD    = 300;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  operation;
	logic [9:0]  row_index;
	logic [31:0] data_value;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] read_value;

	sparse_column_matvec_accumulate #(.ROW_COUNT(ENTRIES)) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.row_index (row_index),
		.data_value(data_value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.read_value(read_value)
	);

	// One row of the directed table
	typedef struct {
		opcode_t     op;
		logic [9:0]  row;
		logic [31:0] data;
		bit          known;
		logic [31:0] known_val;
	} stim_row_t;

	// Shadow of the block's state
	logic [31:0] entry_shadow [ENTRIES];
	logic [31:0] col_shadow;
	bit          row_written [ENTRIES];
	int          written_rows[$];

	logic [31:0] pending_reads[$];

	int  error_count;
	int  cycle_count;
	int  items_sent;
	int  accs_sent;
	int  reads_checked;
	bit  quiet;
	bit  hold_req;

	// Clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Round a magnitude mag * 2^e to binary32, nearest-even
	function automatic logic [31:0] fp32_round(input logic sgn, input logic [66:0] mag,
			input int e);
		int          p;
		int          sh;
		int          bexp;
		logic [66:0] q;
		logic [66:0] rem;
		logic [66:0] half;
		if (mag == '0)
			return {sgn, 31'd0};
		p = 0;
		for (int i = 0; i < 67; i++)
			if (mag[i])
				p = i;
		sh = p - 23;
		if (sh < -149 - e)
			sh = -149 - e;
		if (sh <= 0) begin
			q = mag << (-sh);
		end else if (sh >= 66) begin
			return {sgn, 31'd0};
		end else begin
			q    = mag >> sh;
			rem  = mag & ((67'd1 << sh) - 67'd1);
			half = 67'd1 << (sh - 1);
			if (rem > half || (rem == half && q[0]))
				q = q + 67'd1;
		end
		if (q[24]) begin
			q = q >> 1;
			sh++;
		end
		if (!q[23])
			return {sgn, 8'd0, q[22:0]};
		bexp = 150 + sh + e;
		if (bexp >= 255)
			return {sgn, 8'hFF, 23'd0};
		return {sgn, bexp[7:0], q[22:0]};
	endfunction

	function automatic bit fp32_is_nan(input logic [31:0] v);
		return v[30:23] == 8'hFF && v[22:0] != '0;
	endfunction

	function automatic logic [31:0] fp32_mul(input logic [31:0] a, input logic [31:0] b);
		logic        s;
		logic [66:0] ma;
		logic [66:0] mb;
		int          xa;
		int          xb;
		s = a[31] ^ b[31];
		if (fp32_is_nan(a) || fp32_is_nan(b))
			return CANON_NAN;
		if (a[30:23] == 8'hFF || b[30:23] == 8'hFF) begin
			if (a[30:0] == '0 || b[30:0] == '0)
				return CANON_NAN;
			return {s, 8'hFF, 23'd0};
		end
		if (a[30:0] == '0 || b[30:0] == '0)
			return {s, 31'd0};
		ma = {43'd0, a[30:23] != 8'd0, a[22:0]};
		mb = {43'd0, b[30:23] != 8'd0, b[22:0]};
		xa = (a[30:23] == 8'd0 ? 1 : int'(a[30:23])) - 150;
		xb = (b[30:23] == 8'd0 ? 1 : int'(b[30:23])) - 150;
		return fp32_round(s, ma * mb, xa + xb);
	endfunction

	function automatic logic [31:0] fp32_add(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] t;
		logic [66:0] big;
		logic [66:0] lit;
		logic [66:0] mb;
		int          xa;
		int          xb;
		int          d;
		if (fp32_is_nan(a) || fp32_is_nan(b))
			return CANON_NAN;
		if (a[30:23] == 8'hFF) begin
			if (b[30:23] == 8'hFF && a[31] != b[31])
				return CANON_NAN;
			return a;
		end
		if (b[30:23] == 8'hFF)
			return b;
		if (a[30:0] == '0 && b[30:0] == '0)
			return {a[31] & b[31], 31'd0};
		if (a[30:0] == '0)
			return b;
		if (b[30:0] == '0)
			return a;
		// larger exponent goes first
		if (b[30:23] > a[30:23]) begin
			t = a;
			a = b;
			b = t;
		end
		xa  = (a[30:23] == 8'd0 ? 1 : int'(a[30:23])) - 150;
		xb  = (b[30:23] == 8'd0 ? 1 : int'(b[30:23])) - 150;
		d   = xa - xb;
		big = {43'd0, a[30:23] != 8'd0, a[22:0]} << 40;
		mb  = {43'd0, b[30:23] != 8'd0, b[22:0]};
		if (d <= 40) begin
			lit = mb << (40 - d);
		end else begin
			// far below the rounding point: keep only a sticky bit
			lit = mb >> (d - 40);
			if ((mb & ((67'd1 << (d - 40)) - 67'd1)) != '0)
				lit[0] = 1'b1;
		end
		if (a[31] == b[31])
			return fp32_round(a[31], big + lit, xa - 40);
		if (big == lit)
			return 32'd0;
		if (big > lit)
			return fp32_round(a[31], big - lit, xa - 40);
		return fp32_round(b[31], lit - big, xa - 40);
	endfunction

	// Product rounded, then sum rounded, NaN folded to the canonical one
	function automatic logic [31:0] scatter_mac(input logic [31:0] acc, input logic [31:0] mval,
			input logic [31:0] vval);
		logic [31:0] sum;
		sum = fp32_add(acc, fp32_mul(mval, vval));
		return fp32_is_nan(sum) ? CANON_NAN : sum;
	endfunction

	// Update the shadow state for one accepted item
	task automatic apply_item(input opcode_t op, input logic [9:0] row, input logic [31:0] data,
			input bit known, input logic [31:0] known_val);
		items_sent++;
		case (op)
			OP_WRITE: begin
				entry_shadow[row] = data;
				if (!row_written[row]) begin
					row_written[row] = 1'b1;
					written_rows.push_back(int'(row));
				end
			end
			OP_LOAD: col_shadow = data;
			OP_ACC: begin
				accs_sent++;
				entry_shadow[row] = scatter_mac(entry_shadow[row], data, col_shadow);
			end
			OP_READ: pending_reads.push_back(known ? known_val : entry_shadow[row]);
			default: ;
		endcase
	endtask

	// Offer one item after a random gap; returns after acceptance, at the falling edge
	task automatic send_item(input opcode_t op, input logic [9:0] row, input logic [31:0] data,
			input bit known, input logic [31:0] known_val);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		operation  <= op;
		row_index  <= row;
		data_value <= data;
		in_valid   <= 1'b1;
		do @(posedge clk); while (in_stall);
		apply_item(op, row, data, known, known_val);
		@(negedge clk);
	endtask

	function automatic logic [31:0] rand_fp32();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: begin
				case ($urandom_range(0, 7))
					0: return 32'h0000_0000;
					1: return 32'h8000_0000;
					2: return 32'h7F80_0000;
					3: return 32'hFF80_0000;
					4: return 32'h7FC0_0001;
					5: return 32'h0000_0001;
					6: return 32'h807F_FFFF;
					default: return 32'h7F7F_FFFF;
				endcase
			end
			default: return {1'($urandom), 8'($urandom_range(110, 144)), 23'($urandom)};
		endcase
	endfunction

	function automatic logic [9:0] pick_written();
		return 10'(written_rows[$urandom_range(0, written_rows.size() - 1)]);
	endfunction

	// Result side: random stall per item, one long hold on request
	initial begin
		int gap;
		out_stall = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = quiet ? 0 : $urandom_range(0, 4);
			if (hold_req) begin
				gap      = LONG_HOLD;
				hold_req = 1'b0;
			end
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			if (pending_reads.size() == 0) begin
				$error("read_value: no result expected, got %08h", read_value);
				error_count++;
			end else begin
				logic [31:0] want;
				want = pending_reads.pop_front();
				reads_checked++;
				if (read_value !== want) begin
					$error("read_value: expected %08h, actual %08h", want, read_value);
					error_count++;
				end
			end
			@(negedge clk);
		end
	end

	// Stimulus
	initial begin
		stim_row_t  directed [DIRECTED_N];
		opcode_t    op;
		logic [9:0] row;
		logic [9:0] last_row;
		int         r;

		directed = '{
			'{OP_WRITE, 10'd0,    32'h3F80_0000, 1'b0, 32'h0},
			'{OP_READ,  10'd0,    32'hFFFF_FFFF, 1'b1, 32'h3F80_0000},
			'{OP_WRITE, 10'd1023, 32'hFFFF_FFFF, 1'b0, 32'h0},
			'{OP_READ,  10'd1023, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF},
			'{OP_LOAD,  10'd0,    32'h4000_0000, 1'b0, 32'h0},
			'{OP_ACC,   10'd0,    32'h4040_0000, 1'b0, 32'h0},
			'{OP_READ,  10'd0,    32'h0000_0000, 1'b1, 32'h40E0_0000},
			// infinity times zero gives NaN
			'{OP_WRITE, 10'd5,    32'h7F80_0000, 1'b0, 32'h0},
			'{OP_LOAD,  10'd1023, 32'h0000_0000, 1'b0, 32'h0},
			'{OP_ACC,   10'd5,    32'h7F80_0000, 1'b0, 32'h0},
			'{OP_READ,  10'd5,    32'h0000_0000, 1'b1, 32'h7FC0_0000},
			// exact cancellation gives +0
			'{OP_WRITE, 10'd6,    32'hFF7F_FFFF, 1'b0, 32'h0},
			'{OP_LOAD,  10'd0,    32'h7F7F_FFFF, 1'b0, 32'h0},
			'{OP_ACC,   10'd6,    32'h3F80_0000, 1'b0, 32'h0},
			'{OP_READ,  10'd6,    32'h0000_0000, 1'b1, 32'h0000_0000},
			// product underflows to -0, tie to even
			'{OP_WRITE, 10'd7,    32'h0000_0001, 1'b0, 32'h0},
			'{OP_LOAD,  10'd0,    32'h3F00_0000, 1'b0, 32'h0},
			'{OP_ACC,   10'd7,    32'h8000_0001, 1'b0, 32'h0},
			'{OP_READ,  10'd7,    32'h0000_0000, 1'b1, 32'h0000_0001},
			// sum overflows to infinity
			'{OP_WRITE, 10'd9,    32'h7F7F_FFFF, 1'b0, 32'h0},
			'{OP_LOAD,  10'd0,    32'h7F7F_FFFF, 1'b0, 32'h0},
			'{OP_ACC,   10'd9,    32'h3F80_0000, 1'b0, 32'h0},
			'{OP_READ,  10'd9,    32'h0000_0000, 1'b1, 32'h7F80_0000},
			// a stored NaN entry becomes canonical once accumulated
			'{OP_ACC,   10'd1023, 32'h3F80_0000, 1'b0, 32'h0},
			'{OP_READ,  10'd1023, 32'h0000_0000, 1'b1, 32'h7FC0_0000}
		};

		in_valid   = 1'b0;
		operation  = OP_WRITE;
		row_index  = '0;
		data_value = '0;
		arst_n     = 1'b0;
		clk        = 1'b0;
		col_shadow = 32'h0;
		quiet      = 1'b0;
		hold_req   = 1'b0;
		last_row   = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed[i])
			send_item(directed[i].op, directed[i].row, directed[i].data,
				directed[i].known, directed[i].known_val);

		// Random column loops: writes, loads, runs of accumulates, reads
		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			quiet = (k >= 300 && k < 400);
			if (k == 500)
				hold_req = 1'b1;
			r = (k >= 500 && k < 540) ? 90 : $urandom_range(0, 99);
			if (r < 12) begin
				op  = OP_WRITE;
				row = ($urandom_range(0, 2) == 0) ? pick_written() : 10'($urandom_range(0, 1023));
			end else if (r < 22) begin
				op  = OP_LOAD;
				row = 10'($urandom);
			end else if (r < 75) begin
				op  = OP_ACC;
				row = ($urandom_range(0, 2) == 0) ? last_row : pick_written();
			end else begin
				op  = OP_READ;
				row = ($urandom_range(0, 2) == 0) ? last_row : pick_written();
			end
			if (op != OP_LOAD)
				last_row = row;
			send_item(op, row, (op == OP_READ) ? 32'($urandom) : rand_fp32(), 1'b0, 32'h0);
		end
		in_valid <= 1'b0;

		while (pending_reads.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("Covered %0d items: %0d accumulates, %0d reads checked, over %0d rows.",
			items_sent, accs_sent, reads_checked, written_rows.size());
		$display("Included special values, a quiet stretch and a %0d-cycle result hold.",
			LONG_HOLD);
		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
